FILE: rtl/sorted_char_table_insert_delete_macros.svh
// Assertion macros for the sorted character table.
// Included by the top level; no other dependencies.
`ifndef SORTED_CHAR_TABLE_INSERT_DELETE_MACROS_SVH
`define SORTED_CHAR_TABLE_INSERT_DELETE_MACROS_SVH

// Check a same-cycle implication.
`define SCTID_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sctid check failed");

// Check an implication in the next cycle.
`define SCTID_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sctid check failed");

`endif

FILE: rtl/sctid_pkg.sv
// Types and constants shared by the sorted character table modules.
// No dependencies.
package sctid_pkg;

    localparam int VALUE_W       = 8;
    localparam int POS_W         = 5;
    localparam int ENTRY_COUNT_W = 6;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        status_t                  status;
        logic [POS_W-1:0]         position;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } out_word_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

FILE: rtl/sorted_char_table_insert_delete.sv
// Sorted signed character table with insert and delete, duplicates allowed.
// An insert walks the entries above its position, a delete walks every entry, and a full
// insert does no walk; the memory walk moves one entry per cycle.
// One item is in work at a time; the next is taken the cycle after the result is loaded
// into the output register.
// Reset (aresetn, synchronous, active low) empties the table; no clearing pass.
module sorted_char_table_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sctid_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sctid_pkg::out_word_t  m_data
);
    import sctid_pkg::*;
    `include "sorted_char_table_insert_delete_macros.svh"

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          cursor_reg, cursor_next;
    logic [CNT_W-1:0]          count_new;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic                      found_reg, found_next;
    status_t                   status_reg, status_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      m_valid_reg, m_valid_next;
    out_word_t                 m_data_reg, m_data_next;

    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    cmp_res_t                  cmp;

    sctid_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sctid_cmp u_cmp (
        .a   (rd_data),
        .b   (val_reg),
        .res (cmp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cursor_reg <= cursor_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        val_next     = val_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = IDX_W'(cursor_reg);
        wr_data      = val_reg;
        count_new    = count_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next   = s_data.value;
                    found_next = 1'b0;
                    pos_next   = '0;
                    if (s_data.action == ACT_DELETE) begin
                        cursor_next = '0;
                        state_next  = S_DEL;
                    end else if (count_reg == CNT_W'(CAPACITY)) begin
                        status_next = ST_FULL;
                        state_next  = S_FIN;
                    end else begin
                        cursor_next = count_reg;
                        state_next  = S_INS;
                    end
                end
            end
            S_INS: begin
                wr_en = 1'b1;
                if (cursor_reg == '0) begin
                    wr_addr     = '0;
                    pos_next    = '0;
                    status_next = ST_INSERTED;
                    state_next  = S_FIN;
                end else if (!cmp.lt) begin
                    wr_data     = rd_data;
                    cursor_next = cursor_reg - 1'b1;
                end else begin
                    pos_next    = IDX_W'(cursor_reg);
                    status_next = ST_INSERTED;
                    state_next  = S_FIN;
                end
            end
            S_DEL: begin
                if (cursor_reg == count_reg) begin
                    status_next = found_reg ? ST_DELETED : ST_NOT_FOUND;
                    state_next  = S_FIN;
                end else begin
                    if (found_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(cursor_reg - 1'b1);
                        wr_data = rd_data;
                    end else if (cmp.eq) begin
                        found_next = 1'b1;
                        pos_next   = IDX_W'(cursor_reg);
                    end
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            S_FIN: begin
                case (status_reg)
                    ST_INSERTED: count_new = count_reg + 1'b1;
                    ST_DELETED:  count_new = count_reg - 1'b1;
                    default:     count_new = count_reg;
                endcase
                if (!m_valid_reg || m_ready) begin
                    count_next              = count_new;
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.position    = POS_W'(pos_reg);
                    m_data_next.entry_count = ENTRY_COUNT_W'(count_new);
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (state_next == S_INS) begin
            rd_addr = IDX_W'(cursor_next - 1'b1);
        end else begin
            rd_addr = IDX_W'(cursor_next);
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SCTID_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SCTID_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SCTID_ASSERT_NOW(a_full_pos_zero, aclk, aresetn, m_valid && m_data.status == ST_FULL, m_data.position == '0)
    `SCTID_ASSERT_NOW(a_insert_nonempty, aclk, aresetn, m_valid && m_data.status == ST_INSERTED, count_reg != '0)

endmodule

FILE: rtl/sctid_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on sctid_pkg.
module sctid_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic signed [sctid_pkg::VALUE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [sctid_pkg::VALUE_W-1:0] rd_data
);
    import sctid_pkg::*;

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sctid_cmp.sv
// Shared signed compare unit used by both the insert and delete walks.
// Depends on sctid_pkg.
module sctid_cmp (
    input  logic signed [sctid_pkg::VALUE_W-1:0] a,
    input  logic signed [sctid_pkg::VALUE_W-1:0] b,
    output sctid_pkg::cmp_res_t                  res
);
    import sctid_pkg::*;

    always_comb begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule
